// ===== rtl/core/display_led_beeper_controller_macros.svh =====
// ----------------------------------------------------------------------------
// Display, LED and beeper controller: assertion macros
// Shared forms for the concurrent checks in the controller RTL.
// ----------------------------------------------------------------------------
`ifndef DISPLAY_LED_BEEPER_CONTROLLER_MACROS_SVH
`define DISPLAY_LED_BEEPER_CONTROLLER_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define DLBC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define DLBC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dlbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Display, LED and beeper controller package
// Command and event codes, decode tables and the controller/datapath types.
// ----------------------------------------------------------------------------
`default_nettype none

package dlbc_pkg;

    localparam int CMD_W   = 3;
    localparam int EVENT_W = 3;
    localparam int POS_W   = 7;
    localparam int SEG_W   = 7;
    localparam int HZ_W    = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_ROW    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PORT_A = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PORT_B = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LED    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SOUND  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd5;

    localparam logic [EVENT_W-1:0] EV_DIGIT    = 3'd0;
    localparam logic [EVENT_W-1:0] EV_LED_ON   = 3'd1;
    localparam logic [EVENT_W-1:0] EV_LED_OFF  = 3'd2;
    localparam logic [EVENT_W-1:0] EV_TONE_ON  = 3'd3;
    localparam logic [EVENT_W-1:0] EV_TONE_OFF = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_LED_HOLD  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEP_HOLD = 1'd1;

    localparam logic [7:0] LED_HOLD_RESET  = 8'd48;
    localparam logic [7:0] BEEP_HOLD_RESET = 8'd10;
    localparam logic [7:0] TIMER_RESET     = 8'd5;

    localparam logic [POS_W-1:0] POS_HIGH_STEP = 7'd20;
    localparam logic [POS_W-1:0] POS_PORT_B    = 7'd40;

    // Pending result bits, in emission order. LED off bits follow the last one.
    localparam int P_DIG0     = 0;
    localparam int P_DIG1     = 1;
    localparam int P_LED_ON   = 2;
    localparam int P_TONE_ON  = 3;
    localparam int P_TONE_OFF = 4;
    localparam int P_LED_OFF0 = 5;

    localparam logic [SEG_W-1:0] SEG_TABLE [0:15] = '{
        7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7c, 7'h07,
        7'h7f, 7'h67, 7'h58, 7'h4c, 7'h62, 7'h69, 7'h78, 7'h00
    };

    localparam logic [HZ_W-1:0] TONE_TABLE [0:15] = '{
        11'd387,  11'd435,  11'd488,  11'd517,  11'd581,  11'd652,  11'd691,  11'd775,
        11'd870,  11'd977,  11'd1035, 11'd1161, 11'd1304, 11'd1381, 11'd1550, 11'd1740
    };

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    typedef struct packed {
        logic accept;
        logic exec;
        logic emit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic has_events;
        logic pend_any;
        logic out_free;
        logic emit_last;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== rtl/core/display_led_beeper_controller.sv =====
// ----------------------------------------------------------------------------
// Display, LED and beeper controller
// Decodes panel bus writes into digit, LED and tone events and times out LEDs and tones.
//
//   Channel   Dir  Handshake                  Payload
//   s stream  in   i_s_tvalid / o_s_tready    tdata: data, line_level; tuser: command
//   m stream  out  o_m_tvalid / i_m_tready    tdata: position, segments, tone_hz;
//                                             tuser: event_res; tlast: last
//   cfg       in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A request is accepted and then executed; its results are then emitted in
// order, up to two for a digit write and up to NUM_LEDS plus one for a tick.
// The sequencer emits one result per cycle into a single output register.
// Reset initialises control and timer state and holds both ready outputs low.
// A stalled result holds the sequencer; a new request is taken once the
// last result of the previous one sits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module display_led_beeper_controller #(
    parameter int NUM_LEDS = 8
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    // [7:0] data, [8] line_level, [15:9] zero
    input  wire  [15:0]                         i_s_tdata,
    // [2:0] command
    input  wire  [dlbc_pkg::CMD_W-1:0]          i_s_tuser,
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    // [6:0] position, [13:7] segments, [24:14] tone_hz, [31:25] zero
    output logic [31:0]                         o_m_tdata,
    // [2:0] event_res
    output logic [dlbc_pkg::EVENT_W-1:0]        o_m_tuser,
    output logic                                o_m_tlast,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [dlbc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [7:0]                          i_cfg_data
);

    dlbc_pkg::t_ctrl_cmd  ctrl_cmd;
    dlbc_pkg::t_dp_status dp_status;

    assign o_cfg_ready = i_rst_n;

    dlbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_status   (dp_status),
        .o_cmd      (ctrl_cmd),
        .o_s_tready (o_s_tready)
    );

    dlbc_dpath #(
        .NUM_LEDS (NUM_LEDS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctrl_cmd),
        .o_status    (dp_status),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/core/dlbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Display, LED and beeper controller: sequencer
// Takes one request, starts its execution and paces its results out.
// ----------------------------------------------------------------------------
`default_nettype none

module dlbc_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_s_tvalid,
    input  dlbc_pkg::t_dp_status i_status,
    output dlbc_pkg::t_ctrl_cmd  o_cmd,
    output logic                 o_s_tready
);

    dlbc_pkg::t_state r_state;
    dlbc_pkg::t_state n_state;

    always_comb begin
        o_cmd        = '0;
        o_s_tready   = 1'b0;
        n_state      = r_state;
        case (r_state)
            dlbc_pkg::S_IDLE: begin
                o_s_tready   = i_rst_n;
                o_cmd.accept = i_s_tvalid && i_rst_n;
                if (o_cmd.accept) begin
                    n_state = dlbc_pkg::S_EXEC;
                end
            end
            dlbc_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.has_events ? dlbc_pkg::S_EMIT : dlbc_pkg::S_IDLE;
            end
            dlbc_pkg::S_EMIT: begin
                o_cmd.emit = i_status.out_free && i_status.pend_any;
                if (!i_status.pend_any || (o_cmd.emit && i_status.emit_last)) begin
                    n_state = dlbc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dlbc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dlbc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/dlbc_dpath.sv =====
// ----------------------------------------------------------------------------
// Display, LED and beeper controller: datapath
// Panel state, timers, pending results and the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "display_led_beeper_controller_macros.svh"

module dlbc_dpath #(
    parameter int NUM_LEDS = 8
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  dlbc_pkg::t_ctrl_cmd                 i_cmd,
    output dlbc_pkg::t_dp_status                o_status,
    input  wire  [15:0]                         i_s_tdata,
    input  wire  [dlbc_pkg::CMD_W-1:0]          i_s_tuser,
    input  wire                                 i_cfg_valid,
    input  wire  [dlbc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [7:0]                          i_cfg_data,
    input  wire                                 i_m_tready,
    output logic                                o_m_tvalid,
    output logic [31:0]                         o_m_tdata,
    output logic [dlbc_pkg::EVENT_W-1:0]        o_m_tuser,
    output logic                                o_m_tlast
);

    localparam int LED_IW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int PW     = NUM_LEDS + dlbc_pkg::P_LED_OFF0;

    logic [dlbc_pkg::CMD_W-1:0]   r_cmd;
    logic [7:0]                   r_data;
    logic                         r_level;

    logic [7:0]                   r_led_hold;
    logic [7:0]                   r_beep_hold;
    logic [3:0]                   r_row;
    logic [7:0]                   r_count;
    logic [7:0]                   r_tone_timer;
    logic [7:0]                   r_led_timer [NUM_LEDS];
    logic [PW-1:0]                r_pend;
    logic [dlbc_pkg::POS_W-1:0]   r_dig_base;

    logic                         r_out_valid;
    logic [dlbc_pkg::EVENT_W-1:0] r_out_event;
    logic [dlbc_pkg::POS_W-1:0]   r_out_pos;
    logic [dlbc_pkg::SEG_W-1:0]   r_out_seg;
    logic [dlbc_pkg::HZ_W-1:0]    r_out_hz;
    logic                         r_out_last;

    logic [PW-1:0]                n_pend;
    logic [7:0]                   count_inc;
    logic                         row_ok;
    logic [PW-1:0]                sel_bit;
    logic [PW-1:0]                pend_rest;
    logic [LED_IW-1:0]            led_idx;
    logic                         out_free;
    logic                         emit_last;

    logic [dlbc_pkg::EVENT_W-1:0] n_out_event;
    logic [dlbc_pkg::POS_W-1:0]   n_out_pos;
    logic [dlbc_pkg::SEG_W-1:0]   n_out_seg;
    logic [dlbc_pkg::HZ_W-1:0]    n_out_hz;

    always_comb begin
        n_pend    = '0;
        count_inc = r_count + 8'd1;
        row_ok    = {1'b0, r_row} < 5'(NUM_LEDS);
        case (r_cmd)
            dlbc_pkg::CMD_PORT_A: begin
                if (count_inc == 8'd1) begin
                    n_pend[dlbc_pkg::P_DIG0] = 1'b1;
                    n_pend[dlbc_pkg::P_DIG1] = 1'b1;
                end
            end
            dlbc_pkg::CMD_PORT_B: begin
                if (count_inc == 8'd2) begin
                    n_pend[dlbc_pkg::P_DIG0] = 1'b1;
                    n_pend[dlbc_pkg::P_DIG1] = 1'b1;
                end
            end
            dlbc_pkg::CMD_LED: begin
                n_pend[dlbc_pkg::P_LED_ON] = !r_level && row_ok;
            end
            dlbc_pkg::CMD_SOUND: begin
                n_pend[dlbc_pkg::P_TONE_ON] = 1'b1;
            end
            dlbc_pkg::CMD_TICK: begin
                n_pend[dlbc_pkg::P_TONE_OFF] = (r_tone_timer == 8'd1);
                for (int i = 0; i < NUM_LEDS; i++) begin
                    n_pend[dlbc_pkg::P_LED_OFF0 + i] = (r_led_timer[i] == 8'd1);
                end
            end
            default: begin
                n_pend = '0;
            end
        endcase
    end

    always_comb begin
        sel_bit   = r_pend & (~r_pend + PW'(1));
        pend_rest = r_pend & ~sel_bit;
        emit_last = (pend_rest == '0);
        out_free  = !r_out_valid || i_m_tready;
        led_idx   = '0;
        for (int k = 0; k < NUM_LEDS; k++) begin
            if (sel_bit[dlbc_pkg::P_LED_OFF0 + k]) begin
                led_idx = led_idx | LED_IW'(k);
            end
        end
        n_out_event = dlbc_pkg::EV_LED_OFF;
        n_out_pos   = dlbc_pkg::POS_W'(led_idx);
        n_out_seg   = '0;
        n_out_hz    = '0;
        if (sel_bit[dlbc_pkg::P_DIG0]) begin
            n_out_event = dlbc_pkg::EV_DIGIT;
            n_out_pos   = r_dig_base;
            n_out_seg   = dlbc_pkg::SEG_TABLE[r_data[3:0]];
        end else if (sel_bit[dlbc_pkg::P_DIG1]) begin
            n_out_event = dlbc_pkg::EV_DIGIT;
            n_out_pos   = r_dig_base + dlbc_pkg::POS_HIGH_STEP;
            n_out_seg   = dlbc_pkg::SEG_TABLE[r_data[7:4]];
        end else if (sel_bit[dlbc_pkg::P_LED_ON]) begin
            n_out_event = dlbc_pkg::EV_LED_ON;
            n_out_pos   = {3'b000, r_row};
        end else if (sel_bit[dlbc_pkg::P_TONE_ON]) begin
            n_out_event = dlbc_pkg::EV_TONE_ON;
            n_out_pos   = '0;
            n_out_hz    = dlbc_pkg::TONE_TABLE[r_data[3:0]];
        end else if (sel_bit[dlbc_pkg::P_TONE_OFF]) begin
            n_out_event = dlbc_pkg::EV_TONE_OFF;
            n_out_pos   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd   <= i_s_tuser;
            r_data  <= i_s_tdata[7:0];
            r_level <= i_s_tdata[8];
        end
        if (i_cmd.exec) begin
            r_dig_base <= (r_cmd == dlbc_pkg::CMD_PORT_B) ?
                          ({3'b000, r_row} + dlbc_pkg::POS_PORT_B) : {3'b000, r_row};
        end
        if (i_cmd.emit) begin
            r_out_event <= n_out_event;
            r_out_pos   <= n_out_pos;
            r_out_seg   <= n_out_seg;
            r_out_hz    <= n_out_hz;
            r_out_last  <= emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_hold   <= dlbc_pkg::LED_HOLD_RESET;
            r_beep_hold  <= dlbc_pkg::BEEP_HOLD_RESET;
            r_row        <= '0;
            r_count      <= '0;
            r_tone_timer <= dlbc_pkg::TIMER_RESET;
            for (int i = 0; i < NUM_LEDS; i++) begin
                r_led_timer[i] <= dlbc_pkg::TIMER_RESET;
            end
            r_pend       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == dlbc_pkg::CFG_LED_HOLD) begin
                    r_led_hold <= i_cfg_data;
                end else begin
                    r_beep_hold <= i_cfg_data;
                end
            end
            if (i_cmd.exec) begin
                r_pend <= n_pend;
                case (r_cmd)
                    dlbc_pkg::CMD_ROW: begin
                        r_row   <= r_data[3:0];
                        r_count <= '0;
                    end
                    dlbc_pkg::CMD_PORT_A, dlbc_pkg::CMD_PORT_B: begin
                        r_count <= count_inc;
                    end
                    dlbc_pkg::CMD_LED: begin
                        if (!r_level && row_ok) begin
                            r_led_timer[r_row[LED_IW-1:0]] <= r_led_hold;
                        end
                    end
                    dlbc_pkg::CMD_SOUND: begin
                        r_tone_timer <= r_beep_hold;
                    end
                    dlbc_pkg::CMD_TICK: begin
                        if (r_tone_timer != 8'd0) begin
                            r_tone_timer <= r_tone_timer - 8'd1;
                        end
                        for (int i = 0; i < NUM_LEDS; i++) begin
                            if (r_led_timer[i] != 8'd0) begin
                                r_led_timer[i] <= r_led_timer[i] - 8'd1;
                            end
                        end
                    end
                    default: begin
                        r_count <= r_count;
                    end
                endcase
            end else if (i_cmd.emit) begin
                r_pend <= pend_rest;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.has_events = (n_pend != '0);
    assign o_status.pend_any   = (r_pend != '0);
    assign o_status.out_free   = out_free;
    assign o_status.emit_last  = emit_last;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0000000, r_out_hz, r_out_seg, r_out_pos};
    assign o_m_tuser  = r_out_event;
    assign o_m_tlast  = r_out_last;

    `DLBC_ASSERT_NOW(a_emit_has_room, i_cmd.emit, out_free && (r_pend != '0), "emit without room")
    `DLBC_ASSERT_NOW(a_exec_alone, i_cmd.exec, !i_cmd.emit && !i_cmd.accept, "exec overlaps")
    `DLBC_ASSERT_NEXT(a_quiet_exec, i_cmd.exec && (n_pend == '0), r_pend == '0, "stray pending")
    `DLBC_ASSERT_NEXT(a_last_drains, i_cmd.emit && emit_last, (r_pend == '0) && r_out_last, "last lost")

endmodule

`default_nettype wire
